### design/vmm_pkg.sv
// Shared types and codes for the voltmeter min/max/average tracker.
package vmm_pkg;

    // Input beat opcodes (carried on s_tuser)
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIFF_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALARM_ENABLE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THRESH   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_THRESH  = 2'd3;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } vmm_state_t;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } vmm_div_stat_t;

endpackage

### design/voltmeter_min_max_average_alarm_top.sv
// Top level of the voltmeter min/max/average tracker with window alarm.
//
// Input channel (s_*): one beat carries two converter samples and an opcode.
// The opcode on s_tuser either adds the reading to the running statistics
// or clears them first and starts a new run with this reading.
// Output channel (m_*): one beat per input beat with the reading, minimum,
// maximum, truncated mean, alarm flag and saturating reading count.
// Configuration: cfg_we/cfg_index/cfg_data write the mode, alarm enable and
// the two alarm thresholds; write only while no beat is in flight.
// Timing: min, max, sum and count update in the accept cycle; the mean then
// comes from a restoring divider that produces one quotient bit per
// cycle over the 35-bit sum (SAMPLE_BITS+1+COUNT_WIDTH bits in general).
// s_tready is low from the accept of an item until its result beat.
// The result waits in an output register; while the receiver stalls the
// sequencer holds the finished mean and takes no new beat.
// Reset: differential mode on, alarm off, thresholds 307 and 920 counts,
// statistics cleared (min 1023, max -1023, sum and count zero).
module voltmeter_min_max_average_alarm_top #(
    parameter int unsigned COUNT_WIDTH = 24,
    parameter int unsigned SAMPLE_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // s_tdata: sample_a, sample_b (zero padded to bytes)
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // s_tuser: opcode
    input  logic                                   s_tuser,
    // m_tdata: reading, minimum, maximum, average, alarm, sample_count
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [((4*SAMPLE_BITS+5+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
    input  logic                                   cfg_we,
    input  logic [vmm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [SAMPLE_BITS-1:0]                 cfg_data
);
    import vmm_pkg::*;

    localparam int unsigned RW       = SAMPLE_BITS + 1;
    localparam int unsigned SW       = RW + COUNT_WIDTH;
    localparam int unsigned OUT_W    = ((4*SAMPLE_BITS+5+COUNT_WIDTH+7)/8)*8;
    localparam int          SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
    localparam logic signed [RW-1:0] MIN_RST = RW'(SAMPLE_MAX);
    localparam logic signed [RW-1:0] MAX_RST = RW'(-SAMPLE_MAX);
    // 1.5 V and 4.5 V of a 5 V full scale
    localparam logic [SAMPLE_BITS-1:0] LOW_RST  = SAMPLE_BITS'((SAMPLE_MAX*3+5)/10);
    localparam logic [SAMPLE_BITS-1:0] HIGH_RST = SAMPLE_BITS'((SAMPLE_MAX*9)/10);

    vmm_state_t state_reg, state_next;

    logic                   diff_mode_reg;
    logic                   alarm_en_reg;
    logic [SAMPLE_BITS-1:0] low_thr_reg;
    logic [SAMPLE_BITS-1:0] high_thr_reg;

    logic signed [RW-1:0]   min_reg, min_next;
    logic signed [RW-1:0]   max_reg, max_next;
    logic signed [SW-1:0]   sum_reg, sum_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic signed [RW-1:0]   reading_reg;
    logic                   alarm_reg;

    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg, m_tdata_next;

    logic                   s_beat;
    logic                   out_free;
    logic                   clear;
    logic signed [RW-1:0]   a_ext, b_ext, reading;
    logic [RW-1:0]          mag_full;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   alarm;
    logic signed [RW-1:0]   base_min, base_max;
    logic signed [SW-1:0]   base_sum;
    logic [COUNT_WIDTH-1:0] base_cnt;
    logic                   cnt_sat;

    logic signed [RW-1:0]   avg;
    vmm_div_stat_t          div_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_mode_reg <= 1'b1;
            alarm_en_reg  <= 1'b0;
            low_thr_reg   <= LOW_RST;
            high_thr_reg  <= HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DIFF_MODE:    diff_mode_reg <= cfg_data[0];
                CFG_ALARM_ENABLE: alarm_en_reg  <= cfg_data[0];
                CFG_LOW_THRESH:   low_thr_reg   <= cfg_data;
                CFG_HIGH_THRESH:  high_thr_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Reading and window check
    always_comb
    begin
        a_ext    = $signed({1'b0, s_tdata[SAMPLE_BITS-1:0]});
        b_ext    = $signed({1'b0, s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]});
        reading  = diff_mode_reg ? (a_ext - b_ext) : a_ext;
        mag_full = reading[RW-1] ? RW'(-reading) : RW'(reading);
        mag      = mag_full[SAMPLE_BITS-1:0];
        alarm    = alarm_en_reg && ((mag < low_thr_reg) || (mag > high_thr_reg));
    end

    // Statistics update, clear first when the opcode asks
    always_comb
    begin
        clear    = (s_tuser == OP_CLEAR);
        base_min = clear ? MIN_RST : min_reg;
        base_max = clear ? MAX_RST : max_reg;
        base_sum = clear ? '0 : sum_reg;
        base_cnt = clear ? '0 : cnt_reg;
        cnt_sat  = (base_cnt == {COUNT_WIDTH{1'b1}});
        cnt_next = cnt_sat ? base_cnt : base_cnt + COUNT_WIDTH'(1);
        sum_next = cnt_sat ? base_sum : base_sum + SW'(reading);
        min_next = (reading < base_min) ? reading : base_min;
        max_next = (reading > base_max) ? reading : base_max;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RST;
            max_reg <= MAX_RST;
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (s_beat)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold the reading and alarm for the result beat
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            reading_reg <= reading;
            alarm_reg   <= alarm;
        end
    end

    // Mean: iterative divider, started on the accept cycle
    vmm_div #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (COUNT_WIDTH),
        .QUOT_W     (RW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_beat),
        .dividend (sum_next),
        .divisor  (cnt_next),
        .quotient (avg),
        .stat     (div_stat)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_beat) state_next = ST_DIV;
            ST_DIV:  if (div_stat.done && !div_stat.busy) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Output register: load when the slot is free, drop on a taken beat
    assign m_tdata_next = OUT_W'({cnt_reg, alarm_reg, avg, max_reg, min_reg, reading_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (state_reg == ST_OUT && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

### design/vmm_div.sv
// Iterative signed-by-unsigned restoring divider, one quotient bit per cycle.
module vmm_div #(
    parameter int unsigned DIVIDEND_W = 35,
    parameter int unsigned DIVISOR_W  = 24,
    parameter int unsigned QUOT_W     = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [DIVIDEND_W-1:0]  dividend,
    input  logic        [DIVISOR_W-1:0]   divisor,
    output logic signed [QUOT_W-1:0]      quotient,
    output vmm_pkg::vmm_div_stat_t        stat
);
    import vmm_pkg::*;

    localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

    logic [STEP_W-1:0]     step_reg;
    logic                  done_reg;
    logic                  neg_reg;
    logic [DIVIDEND_W-1:0] dq_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;

    logic [DIVIDEND_W-1:0] mag;
    logic [DIVISOR_W:0]    trial;
    logic                  ge;
    logic [DIVISOR_W:0]    diff;
    logic [QUOT_W-1:0]     q_mag;

    // Magnitude of the dividend; the quotient sign is applied at the end
    assign mag = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    // Control: step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == STEP_W'(1));
            if (start)
            begin
                step_reg <= STEP_W'(DIVIDEND_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    // Datapath: remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= mag;
            neg_reg <= dividend[DIVIDEND_W-1];
            dvs_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            dq_reg  <= {dq_reg[DIVIDEND_W-2:0], ge};
        end
    end

    // Truncate toward zero: negate the magnitude quotient when needed
    assign q_mag    = dq_reg[QUOT_W-1:0];
    assign quotient = neg_reg ? $signed(-q_mag) : $signed(q_mag);

    assign stat.busy = (step_reg != '0);
    assign stat.done = done_reg;

endmodule

### design/vmm_checker.sv
// Port-level checks for the voltmeter tracker, bound to the top level.
module vmm_checker #(
    parameter int unsigned COUNT_WIDTH = 24,
    parameter int unsigned SAMPLE_BITS = 10
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_tvalid,
    input logic                                   s_tready,
    input logic                                   m_tvalid,
    input logic                                   m_tready,
    input logic [((4*SAMPLE_BITS+5+COUNT_WIDTH+7)/8)*8-1:0] m_tdata
);
    localparam int unsigned RW    = SAMPLE_BITS + 1;
    localparam int unsigned CNT_LO = 4*RW + 1;

    logic signed [RW-1:0] min_f, max_f;

    assign min_f = $signed(m_tdata[2*RW-1:RW]);
    assign max_f = $signed(m_tdata[3*RW-1:2*RW]);

    // One item at a time: no new beat right after an accepted one
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // A result cannot appear right after an input beat
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result beat too soon after input");

    // A stalled result beat holds
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // Every result counts at least the current reading
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[CNT_LO+COUNT_WIDTH-1:CNT_LO] != '0)
        else $error("result with zero reading count");

    // Minimum never exceeds maximum once a reading is in
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> min_f <= max_f)
        else $error("minimum above maximum");

endmodule

bind voltmeter_min_max_average_alarm_top vmm_checker #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_vmm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/tb_voltmeter_min_max_average_alarm_top.sv
// Self-checking bench for the voltmeter min/max/average tracker: predicted results versus result beats.
module tb_voltmeter_min_max_average_alarm_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vmm_pkg::*;

    localparam int unsigned SAMPLE_W      = 10;
    localparam int unsigned COUNT_W       = 24;
    localparam int unsigned SUM_W         = SAMPLE_W + 1 + COUNT_W;
    localparam int unsigned S_DATA_W      = ((2*SAMPLE_W+7)/8)*8;
    localparam int unsigned M_DATA_W      = ((4*SAMPLE_W+5+COUNT_W+7)/8)*8;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_BEATS   = 235;
    localparam int unsigned MAX_IDLE      = 16;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE    = 10'd1023;
    localparam logic [SAMPLE_W-1:0] RESET_LOW_TH  = 10'd307;
    localparam logic [SAMPLE_W-1:0] RESET_HIGH_TH = 10'd920;

    typedef struct {
        logic signed [SAMPLE_W:0] reading;
        logic signed [SAMPLE_W:0] minimum;
        logic signed [SAMPLE_W:0] maximum;
        logic signed [SAMPLE_W:0] average;
        logic                     alarm;
        logic [COUNT_W-1:0]       sample_count;
    } meter_result_t;

    // Tracks the running statistics and the queue of predicted result beats
    class meter_scoreboard;
        logic                       diff_mode;
        logic                       alarm_en;
        logic [SAMPLE_W-1:0]        low_th;
        logic [SAMPLE_W-1:0]        high_th;
        logic signed [SAMPLE_W:0]   run_min;
        logic signed [SAMPLE_W:0]   run_max;
        logic signed [SUM_W-1:0]    run_sum;
        logic [COUNT_W-1:0]         run_count;
        meter_result_t              pending_q[$];
        int unsigned                mismatches;
        int unsigned                beats_checked;
        int unsigned                alarms_seen;
        int unsigned                clears_seen;

        function new();
            diff_mode     = 1'b1;
            alarm_en      = 1'b0;
            low_th        = RESET_LOW_TH;
            high_th       = RESET_HIGH_TH;
            mismatches    = 0;
            beats_checked = 0;
            alarms_seen   = 0;
            clears_seen   = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            run_min   = $signed({1'b0, FULL_SCALE});
            run_max   = -$signed({1'b0, FULL_SCALE});
            run_sum   = '0;
            run_count = '0;
        endfunction

        // Mirror a register write, keeping only the register's own bits
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [SAMPLE_W-1:0] value);
            case (idx)
                CFG_DIFF_MODE:    diff_mode = value[0];
                CFG_ALARM_ENABLE: alarm_en  = value[0];
                CFG_LOW_THRESH:   low_th    = value;
                CFG_HIGH_THRESH:  high_th   = value;
                default:          ;
            endcase
        endfunction

        // Work out the result for one accepted input beat
        function void note_input(logic op, logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b);
            int            r;
            int unsigned   mag;
            longint        total;
            meter_result_t res;
            r   = diff_mode ? int'(a) - int'(b) : int'(a);
            mag = (r < 0) ? -r : r;
            if (op == OP_CLEAR)
            begin
                clear_stats();
                clears_seen++;
            end
            // hold sum and count once the count has saturated
            if (run_count != '1)
            begin
                run_count = run_count + 1'b1;
                run_sum   = run_sum + SUM_W'(r);
            end
            if (r < run_min)
                run_min = (SAMPLE_W+1)'(r);
            if (r > run_max)
                run_max = (SAMPLE_W+1)'(r);
            total            = longint'(run_sum);
            res.reading      = (SAMPLE_W+1)'(r);
            res.minimum      = run_min;
            res.maximum      = run_max;
            res.average      = (SAMPLE_W+1)'(total / longint'(run_count));
            res.alarm        = alarm_en && (mag < low_th || mag > high_th);
            res.sample_count = run_count;
            if (res.alarm)
                alarms_seen++;
            pending_q.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, logic signed [63:0] got, logic signed [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0d, expected %0d (beat %0d)",
                                          name, got, want, beats_checked));
        endtask

        // Compare one result beat against the oldest prediction
        task check_result(logic [M_DATA_W-1:0] beat);
            meter_result_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch($sformatf("result beat with nothing expected, data %h", beat));
            end
            else
            begin
                want = pending_q.pop_front();
                compare_field("reading", 64'($signed(beat[10:0])), 64'(want.reading));
                compare_field("minimum", 64'($signed(beat[21:11])), 64'(want.minimum));
                compare_field("maximum", 64'($signed(beat[32:22])), 64'(want.maximum));
                compare_field("average", 64'($signed(beat[43:33])), 64'(want.average));
                compare_field("alarm", {63'd0, beat[44]}, {63'd0, want.alarm});
                compare_field("sample_count", {40'd0, beat[68:45]}, {40'd0, want.sample_count});
            end
            beats_checked++;
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata   = '0;
    logic                   s_tuser   = OP_SAMPLE;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_DIFF_MODE;
    logic [SAMPLE_W-1:0]    cfg_data  = '0;

    meter_scoreboard sb;
    int unsigned     max_gap     = MAX_IDLE;
    int unsigned     max_stall   = MAX_IDLE;
    int unsigned     quiet_cycles = 0;
    int unsigned     beats_sent  = 0;
    int unsigned     settings_run = 0;

    voltmeter_min_max_average_alarm_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Note accepted beats on both sides and count cycles without progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser, s_tdata[9:0], s_tdata[19:10]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // Drop the run if the block stops moving beats
    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[voltmeter_min_max_average_alarm_top] ERROR");
        $finish;
    end

    // Receiver: once a result shows up, hold it off for a random number of cycles
    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, max_stall);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                @(posedge clk);
                while (!m_tvalid)
                    @(posedge clk);
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    // Offer one input beat after a random gap and hold it until taken
    task automatic send_beat(input logic op, input logic [SAMPLE_W-1:0] a,
                             input logic [SAMPLE_W-1:0] b);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-2*SAMPLE_W){1'b0}}, b, a};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    // Write all four registers; the one-bit ones get noise in their unused bits
    task automatic program_regs(input logic diff, input logic alarm_on,
                                input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
        logic [SAMPLE_W-1:0] noise;
        noise = SAMPLE_W'($urandom_range(0, 1023));
        write_reg(CFG_DIFF_MODE, {noise[SAMPLE_W-1:1], diff});
        noise = SAMPLE_W'($urandom_range(0, 1023));
        write_reg(CFG_ALARM_ENABLE, {noise[SAMPLE_W-1:1], alarm_on});
        write_reg(CFG_LOW_THRESH, lo);
        write_reg(CFG_HIGH_THRESH, hi);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial
    begin : stimulus
        logic                op;
        logic                diff;
        logic                alarm_on;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        logic [SAMPLE_W-1:0] a;
        logic [SAMPLE_W-1:0] b;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: differential, alarm off, extremes of both samples
        send_beat(OP_SAMPLE, 10'd0, 10'd0);
        send_beat(OP_SAMPLE, FULL_SCALE, 10'd0);
        send_beat(OP_SAMPLE, 10'd0, FULL_SCALE);
        send_beat(OP_SAMPLE, FULL_SCALE, FULL_SCALE);
        send_beat(OP_SAMPLE, 10'd512, 10'd511);
        drain();

        // Alarm on: zero reading, both window edges, both signs; clear first
        program_regs(1'b1, 1'b1, RESET_LOW_TH, RESET_HIGH_TH);
        send_beat(OP_CLEAR, 10'd0, 10'd0);
        send_beat(OP_SAMPLE, 10'd306, 10'd0);
        send_beat(OP_SAMPLE, 10'd307, 10'd0);
        send_beat(OP_SAMPLE, 10'd920, 10'd0);
        send_beat(OP_SAMPLE, 10'd921, 10'd0);
        send_beat(OP_SAMPLE, 10'd0, 10'd921);
        send_beat(OP_SAMPLE, 10'd0, 10'd306);
        send_beat(OP_SAMPLE, 10'd0, 10'd920);
        drain();

        // Single-ended with the widest window: second sample ignored
        program_regs(1'b0, 1'b1, 10'd0, FULL_SCALE);
        send_beat(OP_SAMPLE, 10'd0, FULL_SCALE);
        send_beat(OP_SAMPLE, FULL_SCALE, 10'd0);
        send_beat(OP_CLEAR, FULL_SCALE, FULL_SCALE);
        drain();

        // Inverted window: low threshold above high threshold
        program_regs(1'b0, 1'b1, FULL_SCALE, 10'd0);
        send_beat(OP_SAMPLE, 10'd0, 10'd0);
        send_beat(OP_SAMPLE, 10'd512, 10'd7);
        send_beat(OP_SAMPLE, FULL_SCALE, FULL_SCALE);
        drain();

        program_regs(1'b1, 1'b0, FULL_SCALE, FULL_SCALE);
        send_beat(OP_CLEAR, FULL_SCALE, 10'd0);
        send_beat(OP_SAMPLE, 10'd0, FULL_SCALE);
        drain();

        // Random phases, each under its own settings; every fourth runs without idling
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            diff     = 1'($urandom_range(0, 1));
            alarm_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 4))
                0:       begin lo = 10'd0;        hi = FULL_SCALE;    end
                1:       begin lo = FULL_SCALE;   hi = 10'd0;         end
                2:       begin lo = RESET_LOW_TH; hi = RESET_HIGH_TH; end
                default:
                begin
                    lo = SAMPLE_W'($urandom_range(0, 1023));
                    hi = SAMPLE_W'($urandom_range(0, 1023));
                end
            endcase
            max_gap   = (phase % 4 == 3) ? 0 : MAX_IDLE;
            max_stall = (phase % 4 == 3) ? 0 : MAX_IDLE;
            program_regs(diff, alarm_on, lo, hi);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                op = ($urandom_range(0, 31) == 0) ? OP_CLEAR : OP_SAMPLE;
                case ($urandom_range(0, 7))
                    0:       a = 10'd0;
                    1:       a = FULL_SCALE;
                    2:       a = SAMPLE_W'(lo + $urandom_range(0, 2) - 1);
                    default: a = SAMPLE_W'($urandom_range(0, 1023));
                endcase
                case ($urandom_range(0, 7))
                    0:       b = 10'd0;
                    1:       b = FULL_SCALE;
                    default: b = SAMPLE_W'($urandom_range(0, 1023));
                endcase
                send_beat(op, a, b);
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (sb.pending_q.size() != 0)
            sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                         sb.pending_q.size()));
        $display("Run covered %0d input beats and %0d result beats over %0d register settings,",
                 beats_sent, sb.beats_checked, settings_run);
        $display("with %0d statistics clears and %0d alarm results; %0d mismatches.",
                 sb.clears_seen, sb.alarms_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[voltmeter_min_max_average_alarm_top] OK");
        else
            $display("[voltmeter_min_max_average_alarm_top] ERROR");
        $finish;
    end

endmodule

### filelist.f
design/vmm_pkg.sv
design/vmm_div.sv
design/voltmeter_min_max_average_alarm_top.sv
design/vmm_checker.sv
sim/tb_voltmeter_min_max_average_alarm_top.sv
